@@ src/aps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants for the alignment priority selector
// Record layout, op and status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEQ_W       = 32;
    localparam logic [31:0] NO_KEY = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_SELECT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FOUND   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic [15:0]        aln_length;
        logic [31:0]        target_key;
        logic [15:0]        query_start;
        logic [15:0]        query_end;
        logic [15:0]        query_length;
        logic [15:0]        target_start;
        logic [15:0]        target_end;
        logic [15:0]        target_length;
    } record_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_PICK,
        S_MOVE,
        S_REPLY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic push;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic scan_last;
        logic pick;
        logic move;
        logic reply;
        status_t reply_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_end;
        logic extendable;
    } dp_stat_t;

    // true when a must leave before b; ties broken by push order (older wins)
    function automatic logic outranks(input record_t a, input logic [SEQ_W-1:0] sa,
                                      input record_t b, input logic [SEQ_W-1:0] sb);
        logic res;
        begin
            if (a.score != b.score)
                res = a.score > b.score;
            else if (a.aln_length != b.aln_length)
                res = a.aln_length > b.aln_length;
            else if (a.target_key != b.target_key)
                res = a.target_key < b.target_key;
            else
                res = sa < sb;
            return res;
        end
    endfunction

endpackage
`default_nettype wire

@@ src/aps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_ctrl: operation sequencer
// Steps push, clear, select and the unused op through the datapath and issues the reply.
// ----------------------------------------------------------------------------
module aps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     op,
    input  wire aps_pkg::dp_stat_t stat,
    output aps_pkg::dp_cmd_t    cmd,
    output logic                busy
);

    aps_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= aps_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aps_pkg::S_IDLE:
            begin
                if (start && op == aps_pkg::OP_SELECT)
                    state_next = stat.empty ? aps_pkg::S_REPLY : aps_pkg::S_SCAN;
                else if (start)
                    state_next = aps_pkg::S_REPLY;
            end
            aps_pkg::S_SCAN:
                if (stat.scan_end)
                    state_next = aps_pkg::S_LAST;
            aps_pkg::S_LAST:  state_next = aps_pkg::S_PICK;
            aps_pkg::S_PICK:  state_next = aps_pkg::S_MOVE;
            aps_pkg::S_MOVE:
            begin
                if (stat.extendable || stat.empty)
                    state_next = aps_pkg::S_REPLY;
                else
                    state_next = aps_pkg::S_SCAN;
            end
            aps_pkg::S_REPLY: state_next = aps_pkg::S_IDLE;
            default:          state_next = aps_pkg::S_IDLE;
        endcase
    end

    // held reply code
    aps_pkg::status_t rstat_reg, rstat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rstat_reg <= aps_pkg::ST_DONE;
        else
            rstat_reg <= rstat_next;
    end

    always_comb
    begin
        rstat_next = rstat_reg;
        if (state_reg == aps_pkg::S_IDLE && start)
        begin
            unique case (op)
                aps_pkg::OP_PUSH:
                    rstat_next = stat.full ? aps_pkg::ST_DROPPED : aps_pkg::ST_DONE;
                aps_pkg::OP_SELECT: rstat_next = aps_pkg::ST_EMPTY;
                default:            rstat_next = aps_pkg::ST_DONE;
            endcase
        end
        else if (state_reg == aps_pkg::S_MOVE && stat.extendable)
            rstat_next = aps_pkg::ST_FOUND;
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.reply_status = rstat_reg;
        busy = (state_reg != aps_pkg::S_IDLE);
        unique case (state_reg)
            aps_pkg::S_IDLE:
            begin
                cmd.push       = start && op == aps_pkg::OP_PUSH && !stat.full;
                cmd.clear      = start && op == aps_pkg::OP_CLEAR;
                cmd.scan_start = start && op == aps_pkg::OP_SELECT;
            end
            aps_pkg::S_SCAN:  cmd.scan_step = 1'b1;
            aps_pkg::S_LAST:  cmd.scan_last = 1'b1;
            aps_pkg::S_PICK:  cmd.pick = 1'b1;
            aps_pkg::S_MOVE:  cmd.move = 1'b1;
            aps_pkg::S_REPLY: cmd.reply = 1'b1;
            default: ;
        endcase
    end

    // assertions
    a_reply_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reply |=> !cmd.reply) else $error("double reply");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("op not taken");
    a_move_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> $past(cmd.pick)) else $error("move without pick");

endmodule
`default_nettype wire

@@ src/aps_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_dp: record store and best-record search
// Unordered slots in a memory; a select scans one slot per cycle for the
// best record, then moves the last slot into the freed one.
// ----------------------------------------------------------------------------
module aps_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire aps_pkg::dp_cmd_t cmd,
    input  wire aps_pkg::record_t in_rec,
    input  wire logic [31:0]     query_key,
    output aps_pkg::dp_stat_t    stat,
    output aps_pkg::record_t     out_rec,
    output logic [1:0]           out_status,
    output logic                 out_strobe
);

    localparam int ENT_W = $bits(aps_pkg::record_t) + aps_pkg::SEQ_W;

    logic [ENT_W-1:0] mem [aps_pkg::QUEUE_DEPTH];
    logic [ENT_W-1:0] rd_reg;

    logic [aps_pkg::CNT_W-1:0] count_reg, count_next;
    logic [aps_pkg::SEQ_W-1:0] seq_reg;
    logic [aps_pkg::IDX_W-1:0] idx_reg;
    logic [aps_pkg::IDX_W-1:0] best_idx_reg;
    aps_pkg::record_t          best_reg;
    logic [aps_pkg::SEQ_W-1:0] best_seq_reg;
    logic                      have_best_reg;
    logic [31:0]               qkey_reg;

    aps_pkg::record_t          rd_rec;
    logic [aps_pkg::SEQ_W-1:0] rd_seq;
    logic [aps_pkg::IDX_W-1:0] last_idx;
    logic [aps_pkg::IDX_W-1:0] rd_addr;
    logic                      take;
    logic                      step_ok;
    logic                      ext_c;

    assign rd_rec   = aps_pkg::record_t'(rd_reg[ENT_W-1 -: $bits(aps_pkg::record_t)]);
    assign rd_seq   = rd_reg[aps_pkg::SEQ_W-1:0];
    assign last_idx = aps_pkg::IDX_W'(count_reg - 1'b1);

    // read address: scan index, or last slot for the compaction move
    always_comb
    begin
        if (cmd.pick)
            rd_addr = last_idx;
        else if (cmd.scan_start || cmd.move)
            rd_addr = '0;
        else
            rd_addr = idx_reg;
    end

    // memory; a move into slot 0 forwards the moved record to the next scan
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[count_reg[aps_pkg::IDX_W-1:0]] <= {in_rec, seq_reg};
        else if (cmd.move)
            mem[best_idx_reg] <= rd_reg;
        if (cmd.move && best_idx_reg == '0)
            rd_reg <= rd_reg;
        else
            rd_reg <= mem[rd_addr];
    end

    assign take = !have_best_reg || aps_pkg::outranks(rd_rec, rd_seq, best_reg, best_seq_reg);

    // with a single record the last step reads past the held slots
    assign step_ok = cmd.scan_step ||
                     (cmd.scan_last && count_reg != aps_pkg::CNT_W'(1));

    // extendability of the chosen record
    always_comb
    begin
        logic right, left;
        right = best_reg.target_start == 16'd0 &&
                (17'(best_reg.target_end) + 17'd1) != 17'(best_reg.target_length);
        left  = best_reg.query_start == 16'd0 &&
                (17'(best_reg.query_end) + 17'd1) != 17'(best_reg.query_length);
        ext_c = (right || left) && !(best_reg.target_start == 16'd0 &&
                best_reg.query_start == 16'd0) && best_reg.target_key != qkey_reg;
    end

    // count, sequence and scan registers
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + 1'b1;
        else if (cmd.clear)
            count_next = '0;
        else if (cmd.pick)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seq_reg       <= '0;
            idx_reg       <= '0;
            have_best_reg <= 1'b0;
            out_strobe    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            out_strobe <= cmd.reply;
            if (cmd.push)
                seq_reg <= seq_reg + 1'b1;
            if (cmd.scan_start || cmd.move)
            begin
                idx_reg       <= aps_pkg::IDX_W'(1);
                have_best_reg <= 1'b0;
            end
            else if (cmd.scan_step || cmd.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (step_ok && take)
                    have_best_reg <= 1'b1;
            end
        end
    end

    // best record and reply payload
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            qkey_reg <= query_key;
        if (step_ok && take)
        begin
            best_reg     <= rd_rec;
            best_seq_reg <= rd_seq;
            best_idx_reg <= aps_pkg::IDX_W'(idx_reg - 1'b1);
        end
        if (cmd.reply)
        begin
            out_status <= cmd.reply_status;
            if (cmd.reply_status == aps_pkg::ST_FOUND)
                out_rec <= best_reg;
            else if (cmd.reply_status == aps_pkg::ST_EMPTY)
                out_rec <= aps_pkg::record_t'({32'd0, aps_pkg::NO_KEY, 96'd0});
            else
                out_rec <= '0;
        end
    end

    // scan covers slots 0..count-1; the registered read data is for the slot before the index
    assign stat.full       = count_reg == aps_pkg::CNT_W'(aps_pkg::QUEUE_DEPTH);
    assign stat.empty      = count_reg == '0;
    assign stat.scan_end   = idx_reg >= last_idx || count_reg == aps_pkg::CNT_W'(1);
    assign stat.extendable = ext_c;

    // assertions
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aps_pkg::CNT_W'(aps_pkg::QUEUE_DEPTH)) else $error("count overflow");
    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> count_reg != '0) else $error("pick from empty store");
    a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> have_best_reg) else $error("no best record");

endmodule
`default_nettype wire

@@ src/alignment_priority_selector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_priority_selector: bounded priority queue of alignment records
// Holds up to QUEUE_DEPTH records; select returns the best extendable one.
// ----------------------------------------------------------------------------
// Usage:
//   An operation is taken when start is high and busy is low; op, query_key
//   and the in_* record ports are sampled at that edge.
//   Every operation gives one result: strobe is high for one cycle with
//   status and the out_* record ports valid. The receiver cannot stall.
//   Push, clear and the unused op: the result passes through the REPLY
//   state and the strobe register; the next transfer can be taken at the
//   edge that ends the strobe cycle. Select: each record examined takes a
//   scan of the record memory at one slot per cycle (one read port), a
//   pick, then a compaction move of the last slot into the freed one.
//   Rejected records repeat that with one slot fewer. After the last record
//   examined the result passes through REPLY and the strobe register. An
//   empty queue goes straight to REPLY.
//   Records tied on score, length and target key leave in push order,
//   tracked by a 32-bit push sequence number stored with each record.
//   Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module alignment_priority_selector (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        query_key,
    input  wire logic signed [15:0] in_score,
    input  wire logic [15:0]        in_aln_length,
    input  wire logic [31:0]        in_target_key,
    input  wire logic [15:0]        in_query_start,
    input  wire logic [15:0]        in_query_end,
    input  wire logic [15:0]        in_query_length,
    input  wire logic [15:0]        in_target_start,
    input  wire logic [15:0]        in_target_end,
    input  wire logic [15:0]        in_target_length,
    output logic                    strobe,
    output logic [1:0]              status,
    output logic signed [15:0]      out_score,
    output logic [15:0]             out_aln_length,
    output logic [31:0]             out_target_key,
    output logic [15:0]             out_query_start,
    output logic [15:0]             out_query_end,
    output logic [15:0]             out_query_length,
    output logic [15:0]             out_target_start,
    output logic [15:0]             out_target_end,
    output logic [15:0]             out_target_length
);

    aps_pkg::dp_cmd_t  cmd;
    aps_pkg::dp_stat_t stat;
    aps_pkg::record_t  in_rec, out_rec;

    // pack incoming record
    always_comb
    begin
        in_rec.score         = in_score;
        in_rec.aln_length    = in_aln_length;
        in_rec.target_key    = in_target_key;
        in_rec.query_start   = in_query_start;
        in_rec.query_end     = in_query_end;
        in_rec.query_length  = in_query_length;
        in_rec.target_start  = in_target_start;
        in_rec.target_end    = in_target_end;
        in_rec.target_length = in_target_length;
    end

    aps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    aps_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_rec     (in_rec),
        .query_key  (query_key),
        .stat       (stat),
        .out_rec    (out_rec),
        .out_status (status),
        .out_strobe (strobe)
    );

    // unpack result record
    assign out_score         = out_rec.score;
    assign out_aln_length    = out_rec.aln_length;
    assign out_target_key    = out_rec.target_key;
    assign out_query_start   = out_rec.query_start;
    assign out_query_end     = out_rec.query_end;
    assign out_query_length  = out_rec.query_length;
    assign out_target_start  = out_rec.target_start;
    assign out_target_end    = out_rec.target_end;
    assign out_target_length = out_rec.target_length;

endmodule
`default_nettype wire

@@ bench/alignment_priority_selector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_priority_selector_test: self-checking bench for the record queue
// Drives push, select, clear and unused commands, predicts results from a behavioural
// copy of the queue (typed rows give their own) and checks each strobed result field by field.
// ----------------------------------------------------------------------------
module alignment_priority_selector_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int QUEUE_SLOTS = 256;

    typedef struct {
        aps_pkg::status_t st;
        aps_pkg::record_t rec;
    } reply_t;

    typedef struct {
        aps_pkg::op_t     op;
        logic [31:0]      qkey;
        aps_pkg::record_t rec;
        bit               typed;
        aps_pkg::status_t st;
        aps_pkg::record_t exp_rec;
    } cmd_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [31:0]        query_key;
    logic signed [15:0] in_score;
    logic [15:0]        in_aln_length;
    logic [31:0]        in_target_key;
    logic [15:0]        in_query_start;
    logic [15:0]        in_query_end;
    logic [15:0]        in_query_length;
    logic [15:0]        in_target_start;
    logic [15:0]        in_target_end;
    logic [15:0]        in_target_length;
    logic               strobe;
    logic [1:0]         status;
    logic signed [15:0] out_score;
    logic [15:0]        out_aln_length;
    logic [31:0]        out_target_key;
    logic [15:0]        out_query_start;
    logic [15:0]        out_query_end;
    logic [15:0]        out_query_length;
    logic [15:0]        out_target_start;
    logic [15:0]        out_target_end;
    logic [15:0]        out_target_length;

    // queue contents in push order, oldest first
    aps_pkg::record_t held_records[$];
    reply_t  pending_results[$];
    int      failures;
    int      cycle_count;
    int      idle_percent;
    int      transfers;
    int      found_count;
    int      dropped_count;

    alignment_priority_selector DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .query_key(query_key), .in_score(in_score), .in_aln_length(in_aln_length),
        .in_target_key(in_target_key), .in_query_start(in_query_start),
        .in_query_end(in_query_end), .in_query_length(in_query_length),
        .in_target_start(in_target_start), .in_target_end(in_target_end),
        .in_target_length(in_target_length), .strobe(strobe), .status(status),
        .out_score(out_score), .out_aln_length(out_aln_length),
        .out_target_key(out_target_key), .out_query_start(out_query_start),
        .out_query_end(out_query_end), .out_query_length(out_query_length),
        .out_target_start(out_target_start), .out_target_end(out_target_end),
        .out_target_length(out_target_length)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("alignment_priority_selector_test failed");
            $finish;
        end
    end

    // true when a leaves before b; older record wins a full tie via scan order
    function automatic bit ranks_above(aps_pkg::record_t a, aps_pkg::record_t b);
        if ($signed(a.score) != $signed(b.score))
            return $signed(a.score) > $signed(b.score);
        if (a.aln_length != b.aln_length)
            return a.aln_length > b.aln_length;
        return a.target_key < b.target_key;
    endfunction

    function automatic bit can_extend(aps_pkg::record_t r, logic [31:0] qkey);
        bit right;
        bit left;
        right = (r.target_start == 0) && ((32'(r.target_end) + 1) != 32'(r.target_length));
        left  = (r.query_start == 0) && ((32'(r.query_end) + 1) != 32'(r.query_length));
        if (r.target_start == 0 && r.query_start == 0)
            return 0;
        if (r.target_key == qkey)
            return 0;
        return right || left;
    endfunction

    // queue behaviour: updates held_records and gives the result of one command
    function automatic reply_t queue_command(aps_pkg::op_t cmd, logic [31:0] qkey,
                                             aps_pkg::record_t rec);
        reply_t           r;
        int               best;
        aps_pkg::record_t pick;
        r.st  = aps_pkg::ST_DONE;
        r.rec = '0;
        case (cmd)
            aps_pkg::OP_PUSH:
            begin
                if (held_records.size() >= QUEUE_SLOTS)
                    r.st = aps_pkg::ST_DROPPED;
                else
                    held_records.insert(held_records.size(), rec);
            end
            aps_pkg::OP_CLEAR:
                held_records.delete();
            aps_pkg::OP_SELECT:
            begin
                r.st = aps_pkg::ST_EMPTY;
                r.rec.target_key = aps_pkg::NO_KEY;
                while (held_records.size() > 0)
                begin
                    best = 0;
                    for (int i = 1; i < held_records.size(); i++)
                        if (ranks_above(held_records[i], held_records[best]))
                            best = i;
                    pick = held_records[best];
                    held_records.delete(best);
                    if (can_extend(pick, qkey))
                    begin
                        r.st  = aps_pkg::ST_FOUND;
                        r.rec = pick;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic aps_pkg::record_t random_record();
        aps_pkg::record_t r;
        r.score         = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 3) * 100 - 150);
        r.aln_length    = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom_range(40, 43));
        r.target_key    = ($urandom_range(0, 4) == 0) ? ($urandom % 32'hFFFF_FFFF) :
                          32'($urandom_range(1, 4));
        r.query_start   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        r.target_start  = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        r.query_end     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        r.target_end    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        r.query_length  = ($urandom_range(0, 2) == 0) ? r.query_end + 16'd1 : 16'($urandom);
        r.target_length = ($urandom_range(0, 2) == 0) ? r.target_end + 16'd1 : 16'($urandom);
        return r;
    endfunction

    // one transfer; typed rows override the predicted result
    task automatic issue(cmd_row_t row);
        reply_t r;
        op               <= row.op;
        query_key        <= row.qkey;
        in_score         <= row.rec.score;
        in_aln_length    <= row.rec.aln_length;
        in_target_key    <= row.rec.target_key;
        in_query_start   <= row.rec.query_start;
        in_query_end     <= row.rec.query_end;
        in_query_length  <= row.rec.query_length;
        in_target_start  <= row.rec.target_start;
        in_target_end    <= row.rec.target_end;
        in_target_length <= row.rec.target_length;
        start            <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = queue_command(row.op, row.qkey, row.rec);
        if (row.typed)
        begin
            r.st  = row.st;
            r.rec = row.exp_rec;
        end
        pending_results.insert(pending_results.size(), r);
        transfers++;
        // sender gap
        if ($urandom_range(0, 99) < idle_percent)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_percent && $urandom_range(0, 30) != 0);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    function automatic cmd_row_t make_row(aps_pkg::op_t cmd, logic [31:0] qkey,
                                          aps_pkg::record_t rec);
        cmd_row_t row;
        row.op      = cmd;
        row.qkey    = qkey;
        row.rec     = rec;
        row.typed   = 0;
        row.st      = aps_pkg::ST_DONE;
        row.exp_rec = '0;
        return row;
    endfunction

    function automatic aps_pkg::record_t mk(int sc, int len, logic [31:0] key, int qs, int qe,
                                            int ql, int ts, int te, int tl);
        aps_pkg::record_t r;
        r.score = 16'(sc); r.aln_length = 16'(len); r.target_key = key;
        r.query_start = 16'(qs); r.query_end = 16'(qe); r.query_length = 16'(ql);
        r.target_start = 16'(ts); r.target_end = 16'(te); r.target_length = 16'(tl);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: status %0d", status);
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (e.st == aps_pkg::ST_FOUND) found_count++;
                if (e.st == aps_pkg::ST_DROPPED) dropped_count++;
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status); failures++;
                end
                if (out_score !== e.rec.score)
                begin
                    $error("out_score: expected %0d, got %0d", e.rec.score, out_score);
                    failures++;
                end
                if (out_aln_length !== e.rec.aln_length)
                begin
                    $error("out_aln_length: expected %0d, got %0d", e.rec.aln_length,
                           out_aln_length);
                    failures++;
                end
                if (out_target_key !== e.rec.target_key)
                begin
                    $error("out_target_key: expected %h, got %h", e.rec.target_key,
                           out_target_key);
                    failures++;
                end
                if (out_query_start !== e.rec.query_start)
                begin
                    $error("out_query_start: expected %0d, got %0d", e.rec.query_start,
                           out_query_start);
                    failures++;
                end
                if (out_query_end !== e.rec.query_end)
                begin
                    $error("out_query_end: expected %0d, got %0d", e.rec.query_end,
                           out_query_end);
                    failures++;
                end
                if (out_query_length !== e.rec.query_length)
                begin
                    $error("out_query_length: expected %0d, got %0d", e.rec.query_length,
                           out_query_length);
                    failures++;
                end
                if (out_target_start !== e.rec.target_start)
                begin
                    $error("out_target_start: expected %0d, got %0d", e.rec.target_start,
                           out_target_start);
                    failures++;
                end
                if (out_target_end !== e.rec.target_end)
                begin
                    $error("out_target_end: expected %0d, got %0d", e.rec.target_end,
                           out_target_end);
                    failures++;
                end
                if (out_target_length !== e.rec.target_length)
                begin
                    $error("out_target_length: expected %0d, got %0d", e.rec.target_length,
                           out_target_length);
                    failures++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        cmd_row_t         table_rows[$];
        cmd_row_t         row;
        aps_pkg::record_t hi_rec;
        int               roll;
        int               push_pct;
        int               wait_cycles;

        failures = 0; cycle_count = 0; transfers = 0; found_count = 0; dropped_count = 0;
        idle_percent = 0;
        rst_n <= 1'b0; start <= 1'b0; op <= aps_pkg::OP_NONE; query_key <= '0;
        in_score <= '0; in_aln_length <= '0; in_target_key <= '0;
        in_query_start <= '0; in_query_end <= '0; in_query_length <= '0;
        in_target_start <= '0; in_target_end <= '0; in_target_length <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty select, unused op, extremes, ties, rejections
        hi_rec = mk(32767, 65535, 0, 5, 0, 0, 0, 10, 20);
        row = make_row(aps_pkg::OP_SELECT, 0, '0); row.typed = 1; row.st = aps_pkg::ST_EMPTY;
        row.exp_rec.target_key = aps_pkg::NO_KEY; table_rows.insert(table_rows.size(), row);
        row = make_row(aps_pkg::OP_NONE, 32'hFFFF_FFFE, mk(-1, 65535, 32'hFFFF_FFFE, 65535,
                       65535, 65535, 65535, 65535, 65535));
        row.typed = 1; table_rows.insert(table_rows.size(), row);
        row = make_row(aps_pkg::OP_PUSH, 0, hi_rec); row.typed = 1;
        table_rows.insert(table_rows.size(), row);
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(-32768, 0, 32'hFFFF_FFFE, 1, 0, 0, 0, 0, 0)));
        // query side at its end: not extendable
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(100, 50, 7, 0, 9, 10, 3, 0, 0)));
        // same keys, pushed later
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(100, 50, 7, 0, 8, 10, 3, 0, 0)));
        // both starts zero
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(100, 50, 9, 0, 1, 10, 0, 1, 10)));
        // target key equal to the query key on select
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(100, 60, 5, 2, 0, 0, 0, 4, 10)));
        row = make_row(aps_pkg::OP_SELECT, 5, '0); row.typed = 1; row.st = aps_pkg::ST_FOUND;
        row.exp_rec = hi_rec; table_rows.insert(table_rows.size(), row);
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_SELECT, 5, '0));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_SELECT, 5, '0));
        row = make_row(aps_pkg::OP_SELECT, 5, '0); row.typed = 1; row.st = aps_pkg::ST_EMPTY;
        row.exp_rec.target_key = aps_pkg::NO_KEY; table_rows.insert(table_rows.size(), row);
        // end + 1 carrying past 16 bits, and a record all ones except the target key
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(-1, 1, 3, 9, 0, 0, 0, 65535, 0)));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(-1, 1, 2, 9, 0, 0, 0, 65535, 65535)));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(-1, 65535, 32'hFFFF_FFFE, 65535, 65535, 65535, 65535, 65535,
                             65535)));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_SELECT, 32'hFFFF_FFFE, '0));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_SELECT, 0, '0));
        table_rows.insert(table_rows.size(), make_row(aps_pkg::OP_PUSH, 0,
                          mk(0, 0, 0, 0, 0, 0, 1, 0, 0)));
        row = make_row(aps_pkg::OP_CLEAR, 0, '0); row.typed = 1;
        table_rows.insert(table_rows.size(), row);
        row = make_row(aps_pkg::OP_SELECT, 0, '0); row.typed = 1; row.st = aps_pkg::ST_EMPTY;
        row.exp_rec.target_key = aps_pkg::NO_KEY; table_rows.insert(table_rows.size(), row);
        foreach (table_rows[i])
            issue(table_rows[i]);
        drain();

        // fill to capacity, one dropped push, three selects, then clear
        idle_percent = 14;
        for (int i = 0; i <= QUEUE_SLOTS; i++)
            issue(make_row(aps_pkg::OP_PUSH, 0, random_record()));
        for (int i = 0; i < 3; i++)
            issue(make_row(aps_pkg::OP_SELECT, 32'($urandom_range(1, 4)), '0));
        issue(make_row(aps_pkg::OP_CLEAR, 0, '0));
        drain();

        // random commands across sender idling phases
        for (int i = 0; i < 700; i++)
        begin
            if (i == 0)   idle_percent = 0;
            if (i == 200) idle_percent = 87;
            if (i == 350) idle_percent = 0;
            if (i == 500) idle_percent = 14;
            if (i == 400) drain();
            push_pct = (held_records.size() > 16) ? 30 : 60;
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                row = make_row(aps_pkg::OP_PUSH, $urandom % 32'hFFFF_FFFF, random_record());
            else if (roll < 93)
                row = make_row(aps_pkg::OP_SELECT,
                               ($urandom_range(0, 2) == 0) ? $urandom % 32'hFFFF_FFFF :
                               32'($urandom_range(1, 4)), random_record());
            else if (roll < 97)
                row = make_row(aps_pkg::OP_CLEAR, $urandom % 32'hFFFF_FFFF, random_record());
            else
                row = make_row(aps_pkg::OP_NONE, $urandom % 32'hFFFF_FFFF, random_record());
            issue(row);
        end

        // wind down
        drain();
        wait_cycles = 0;
        while (wait_cycles < 50)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        $display("Covered %0d transfers: %0d records found, %0d pushes dropped on a full queue,",
                 transfers, found_count, dropped_count);
        $display("ranking ties, rejections, clears and idle sender phases.");
        if (failures == 0 && pending_results.size() == 0)
            $display("alignment_priority_selector_test passed");
        else
            $display("alignment_priority_selector_test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/aps_pkg.sv
src/aps_ctrl.sv
src/aps_dp.sv
src/alignment_priority_selector.sv
bench/alignment_priority_selector_test.sv
